// File: rtl/qpg_pkg.sv
// Shared types, constants and helpers for the quadrature pulse generator.
package qpg_pkg;

    localparam int HOLD_W      = 16;
    localparam int THR_W       = 7;
    localparam int DELTA_W     = 8;
    localparam int PHASE_W     = 2;
    localparam int REM_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_HOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_THR = 2'd2;

    localparam logic [HOLD_W-1:0] MIN_HOLD_RST  = 16'd500;
    localparam logic [HOLD_W-1:0] MAX_HOLD_RST  = 16'd2000;
    localparam logic [THR_W-1:0]  SPEED_THR_RST = 7'd5;

    // hold reduction is scaled by 1/10 of the span
    localparam logic [REM_W:0]    DIVISOR  = 5'd10;
    localparam logic [HOLD_W-1:0] HOLD_SAT = 16'hFFFF;

    localparam logic [PHASE_W-1:0] STEP_FWD = 2'd1;
    localparam logic [PHASE_W-1:0] STEP_REV = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } qpg_state_t;

    // Gray sequence 00,01,11,10 indexed by phase
    function automatic logic gray_a(input logic [PHASE_W-1:0] phase);
        return phase[1];
    endfunction

    function automatic logic gray_b(input logic [PHASE_W-1:0] phase);
        return phase[1] ^ phase[0];
    endfunction

endpackage

// File: rtl/quadrature_pulse_generator.sv
// Quadrature pulse generator: movement delta in, one quadrature step per transaction out.
//
// Input stream: s_tdata holds the signed 8-bit delta, s_tuser the axis (0 X, 1 Y).
// Output stream: one transaction per quadrature step; m_tdata holds line_a, line_b
// and hold_us, m_tuser the axis, m_tlast marks the final step of a delta.
// A delta of zero is taken and produces nothing. |delta| is capped at MAX_PULSES.
// Config: cfg_we/cfg_index/cfg_data write min hold, max hold and speed threshold.
//
// One item is worked on at a time; s_tready is high only while idle.
// The hold time comes from one shared adder under a small sequencer:
// a shift-add multiply over the count bits, then a divide by ten as a
// reciprocal shift-add series with a final correction. When the count is
// at or below the threshold, the first step follows the setup state directly
// with the max hold; otherwise the multiply, abs, divide and finish states
// come first. Steps then leave at one per cycle while m_tready is high; a
// stalled receiver simply holds the current step.
// Reset clears both axis phases and loads the default configuration.
module quadrature_pulse_generator #(
    parameter int MAX_PULSES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [qpg_pkg::DELTA_W-1:0]   s_tdata,   // [7:0] delta
    input  logic                          s_tuser,   // [0] axis
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [qpg_pkg::OUT_TDATA_W-1:0] m_tdata, // [0] line_a, [1] line_b, [17:2] hold_us
    output logic                          m_tuser,   // [0] out_axis
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [qpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [qpg_pkg::HOLD_W-1:0]    cfg_data
);
    import qpg_pkg::*;

    localparam int CNT_W     = $clog2(MAX_PULSES + 1);
    localparam int MAG_W     = HOLD_W + CNT_W;
    localparam int ALU_W     = HOLD_W + CNT_W + 2;
    localparam int DIV_STEPS = 8;
    localparam int ITER_W    = $clog2((CNT_W > DIV_STEPS) ? CNT_W : DIV_STEPS);
    localparam int CMP_W     = (CNT_W > THR_W) ? CNT_W : THR_W;

    localparam logic [DELTA_W:0]  MAX_P_EXT = (DELTA_W + 1)'(MAX_PULSES);
    localparam logic [ITER_W-1:0] MUL_LAST  = ITER_W'(CNT_W - 1);
    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

    // divide-by-ten sequence: q = x*0.8 folded, q >>= 3, r = x - 10q, q += (r > 9)
    localparam logic [ITER_W-1:0] DIV_HALF_QTR = ITER_W'(0);
    localparam logic [ITER_W-1:0] DIV_FOLD4    = ITER_W'(1);
    localparam logic [ITER_W-1:0] DIV_FOLD8    = ITER_W'(2);
    localparam logic [ITER_W-1:0] DIV_FOLD16   = ITER_W'(3);
    localparam logic [ITER_W-1:0] DIV_TIMES10  = ITER_W'(4);
    localparam logic [ITER_W-1:0] DIV_REM      = ITER_W'(5);
    localparam logic [ITER_W-1:0] DIV_CHECK    = ITER_W'(6);
    localparam logic [ITER_W-1:0] DIV_ROUND    = ITER_W'(7);

    qpg_state_t state_reg, state_next;

    logic [HOLD_W-1:0]  min_hold_reg, max_hold_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [PHASE_W-1:0] x_phase_reg, x_phase_next;
    logic [PHASE_W-1:0] y_phase_reg, y_phase_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               axis_reg, axis_next;
    logic               fwd_reg, fwd_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic [CNT_W-1:0]   diff_reg, diff_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [ALU_W-1:0]   span_reg, span_next;
    logic [ALU_W-1:0]   prod_reg, prod_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [HOLD_W-1:0]  hold_reg, hold_next;

    // shared adder/subtractor
    logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
    logic             alu_sub;
    assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(ALU_W-1){1'b0}}, alu_sub};

    logic               in_fire, out_fire;
    logic [DELTA_W:0]   delta_mag;
    logic [CNT_W-1:0]   count_in;
    logic               above_thr;
    logic [PHASE_W-1:0] step_phase;
    logic [ALU_W-1:0]   min_ext;
    logic [ALU_W-1:0]   mag_ext;
    logic [ALU_W-1:0]   quot_ext;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    assign delta_mag = s_tdata[DELTA_W-1] ? ((DELTA_W + 1)'(0) - {s_tdata[DELTA_W-1], s_tdata})
                                          : {1'b0, s_tdata};
    assign count_in  = (delta_mag > MAX_P_EXT) ? CNT_W'(MAX_PULSES) : delta_mag[CNT_W-1:0];
    assign above_thr = CMP_W'(remain_reg) > CMP_W'(thr_reg);
    assign step_phase = phase_reg + (fwd_reg ? STEP_FWD : STEP_REV);
    assign min_ext    = ALU_W'(min_hold_reg);
    assign mag_ext    = ALU_W'(mag_reg);
    assign quot_ext   = prod_reg >> 3;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (s_tdata != '0))
                    state_next = ST_SETUP;
            end
            ST_SETUP: state_next = above_thr ? ST_MUL : ST_EMIT;
            ST_MUL:
            begin
                if (iter_reg == MUL_LAST)
                    state_next = ST_ABS;
            end
            ST_ABS:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (iter_reg == DIV_LAST)
                    state_next = ST_FIN;
            end
            ST_FIN:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_fire && (remain_reg == CNT_ONE))
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // handshake and adder operand selection
    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        alu_a    = '0;
        alu_b    = '0;
        alu_sub  = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SETUP:
            begin
                alu_a   = ALU_W'(max_hold_reg);
                alu_b   = min_ext;
                alu_sub = 1'b1;
            end
            ST_MUL:
            begin
                alu_a = {prod_reg[ALU_W-2:0], 1'b0};
                alu_b = diff_reg[CNT_W-1] ? span_reg : '0;
            end
            ST_ABS:
            begin
                alu_b   = prod_reg;
                alu_sub = 1'b1;
            end
            ST_DIV:
            begin
                case (iter_reg)
                    DIV_HALF_QTR:
                    begin
                        alu_a = mag_ext >> 1;
                        alu_b = mag_ext >> 2;
                    end
                    DIV_FOLD4:
                    begin
                        alu_a = prod_reg;
                        alu_b = prod_reg >> 4;
                    end
                    DIV_FOLD8:
                    begin
                        alu_a = prod_reg;
                        alu_b = prod_reg >> 8;
                    end
                    DIV_FOLD16:
                    begin
                        alu_a = prod_reg;
                        alu_b = prod_reg >> 16;
                    end
                    DIV_TIMES10:
                    begin
                        alu_a = quot_ext << 3;
                        alu_b = quot_ext << 1;
                    end
                    DIV_REM:
                    begin
                        alu_a   = mag_ext;
                        alu_b   = span_reg;
                        alu_sub = 1'b1;
                    end
                    DIV_CHECK:
                    begin
                        alu_a   = span_reg;
                        alu_b   = ALU_W'(DIVISOR);
                        alu_sub = 1'b1;
                    end
                    DIV_ROUND:
                    begin
                        alu_a = quot_ext;
                        alu_b = span_reg;
                    end
                    default: ;
                endcase
            end
            ST_FIN:
            begin
                alu_a   = ALU_W'(max_hold_reg);
                alu_b   = ALU_W'(mag_reg);
                alu_sub = !neg_reg;
            end
            ST_EMIT:  m_tvalid = 1'b1;
            default:  ;
        endcase
    end

    // datapath next values
    always_comb
    begin
        x_phase_next = x_phase_reg;
        y_phase_next = y_phase_reg;
        phase_next   = phase_reg;
        axis_next    = axis_reg;
        fwd_next     = fwd_reg;
        neg_next     = neg_reg;
        remain_next  = remain_reg;
        diff_next    = diff_reg;
        iter_next    = iter_reg;
        span_next    = span_reg;
        prod_next    = prod_reg;
        mag_next     = mag_reg;
        hold_next    = hold_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    axis_next   = s_tuser;
                    fwd_next    = !s_tdata[DELTA_W-1];
                    remain_next = count_in;
                    phase_next  = s_tuser ? y_phase_reg : x_phase_reg;
                end
            end
            ST_SETUP:
            begin
                span_next = alu_sum;
                diff_next = remain_reg - CNT_W'(thr_reg);
                prod_next = '0;
                iter_next = '0;
                hold_next = max_hold_reg;
            end
            ST_MUL:
            begin
                prod_next = alu_sum;
                diff_next = diff_reg << 1;
                iter_next = iter_reg + ITER_W'(1);
            end
            ST_ABS:
            begin
                neg_next  = prod_reg[ALU_W-1];
                mag_next  = prod_reg[ALU_W-1] ? alu_sum[MAG_W-1:0] : prod_reg[MAG_W-1:0];
                iter_next = '0;
            end
            ST_DIV:
            begin
                // prod holds the running estimate, span ten times the quotient, the remainder and then the carry
                case (iter_reg)
                    DIV_HALF_QTR, DIV_FOLD4, DIV_FOLD8, DIV_FOLD16:
                        prod_next = alu_sum;
                    DIV_TIMES10, DIV_REM:
                        span_next = alu_sum;
                    DIV_CHECK:
                        span_next = ALU_W'(!alu_sum[ALU_W-1]);
                    DIV_ROUND:
                        mag_next = alu_sum[MAG_W-1:0];
                    default: ;
                endcase
                iter_next = iter_reg + ITER_W'(1);
            end
            ST_FIN:
            begin
                if ($signed(alu_sum) < $signed(min_ext))
                    hold_next = min_hold_reg;
                else if ($signed(alu_sum) > $signed(ALU_W'(HOLD_SAT)))
                    hold_next = HOLD_SAT;
                else
                    hold_next = alu_sum[HOLD_W-1:0];
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    phase_next  = step_phase;
                    remain_next = remain_reg - CNT_ONE;
                    if (remain_reg == CNT_ONE)
                    begin
                        if (axis_reg)
                            y_phase_next = step_phase;
                        else
                            x_phase_next = step_phase;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            x_phase_reg <= '0;
            y_phase_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            x_phase_reg <= x_phase_next;
            y_phase_reg <= y_phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_hold_reg <= MIN_HOLD_RST;
            max_hold_reg <= MAX_HOLD_RST;
            thr_reg      <= SPEED_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_HOLD:  min_hold_reg <= cfg_data;
                REG_MAX_HOLD:  max_hold_reg <= cfg_data;
                REG_SPEED_THR: thr_reg      <= cfg_data[THR_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg  <= phase_next;
        axis_reg   <= axis_next;
        fwd_reg    <= fwd_next;
        neg_reg    <= neg_next;
        remain_reg <= remain_next;
        diff_reg   <= diff_next;
        iter_reg   <= iter_next;
        span_reg   <= span_next;
        prod_reg   <= prod_next;
        mag_reg    <= mag_next;
        hold_reg   <= hold_next;
    end

    assign m_tdata = {{(OUT_TDATA_W - HOLD_W - 2){1'b0}}, hold_reg,
                      gray_b(step_phase), gray_a(step_phase)};
    assign m_tuser = axis_reg;
    assign m_tlast = (remain_reg == CNT_ONE);

endmodule

// File: rtl/qpg_checker.sv
// Port-level checks for the quadrature pulse generator, bound to the top level.
module qpg_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [qpg_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                             m_tlast
);
    import qpg_pkg::*;

    // one item at a time: never taking input while a step is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while output valid");

    // stalled step holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output changed");

    // a run continues right after a non-final step with the same hold time
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && $stable(m_tdata[HOLD_W+1:2])))
        else $error("run broken or hold changed within a run");

    // consecutive steps of a run differ in exactly one line
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            ($countones(m_tdata[1:0] ^ $past(m_tdata[1:0])) == 1))
        else $error("quadrature lines did not take a single Gray step");

endmodule

bind quadrature_pulse_generator qpg_checker u_qpg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/tb_quadrature_pulse_generator.sv
// Self-checking testbench for the quadrature pulse generator stream block.
module tb_quadrature_pulse_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import qpg_pkg::*;

    localparam int MAX_STEPS    = 64;
    localparam int CYCLE_LIMIT  = 1_000_000;
    // worst-case setup before the first step fits within the settle time
    localparam int SETTLE_CYCLES = 48;
    localparam int SEGMENTS      = 9;
    localparam int ITEMS_PER_SEG = 29;

    // not decoded by the block, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // line levels indexed by phase, Gray order 00,01,11,10
    localparam bit [3:0] LINE_A_BY_PHASE = 4'b1100;
    localparam bit [3:0] LINE_B_BY_PHASE = 4'b0110;

    class qpg_step_scoreboard;
        typedef struct {
            logic              axis;
            logic              line_a;
            logic              line_b;
            logic [HOLD_W-1:0] hold_us;
            logic              last;
        } step_t;

        logic [HOLD_W-1:0]  min_hold;
        logic [HOLD_W-1:0]  max_hold;
        logic [THR_W-1:0]   speed_thr;
        logic [PHASE_W-1:0] phase [2];
        step_t              pending_steps [$];
        int                 errors;

        function new();
            min_hold  = 16'd500;
            max_hold  = 16'd2000;
            speed_thr = 7'd5;
            phase[0]  = '0;
            phase[1]  = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [HOLD_W-1:0] value);
            case (idx)
                REG_MIN_HOLD:  min_hold  = value;
                REG_MAX_HOLD:  max_hold  = value;
                REG_SPEED_THR: speed_thr = value[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [HOLD_W-1:0] hold_for_count(int count);
            longint d;
            if (count <= int'(speed_thr))
                return max_hold;
            d = longint'(max_hold) -
                ((longint'(count) - longint'(speed_thr)) *
                 (longint'(max_hold) - longint'(min_hold))) / 10;
            if (d < longint'(min_hold))
                d = longint'(min_hold);
            if (d > 65535)
                d = 65535;
            return d[HOLD_W-1:0];
        endfunction

        // expand one accepted delta into its quadrature steps
        function void note_delta(logic axis, logic [DELTA_W-1:0] delta);
            bit                 fwd;
            int                 count;
            logic [HOLD_W-1:0]  hold;
            logic [PHASE_W-1:0] ph;
            step_t              s;
            if (delta == '0)
                return;
            fwd   = !delta[DELTA_W-1];
            count = fwd ? int'(delta) : 256 - int'(delta);
            if (count > MAX_STEPS)
                count = MAX_STEPS;
            hold = hold_for_count(count);
            ph   = phase[axis];
            for (int i = 0; i < count; i++) begin
                ph = fwd ? ph + 2'd1 : ph - 2'd1;
                s.axis    = axis;
                s.line_a  = LINE_A_BY_PHASE[ph];
                s.line_b  = LINE_B_BY_PHASE[ph];
                s.hold_us = hold;
                s.last    = (i == count - 1);
                pending_steps.push_back(s);
            end
            phase[axis] = ph;
        endfunction

        function void check_step(logic axis, logic line_a, logic line_b,
                                 logic [HOLD_W-1:0] hold_us, logic last);
            step_t s;
            if (pending_steps.size() == 0) begin
                $error("unexpected step: axis %0d a %0d b %0d hold_us %0d last %0d",
                       axis, line_a, line_b, hold_us, last);
                errors++;
                return;
            end
            s = pending_steps.pop_front();
            if (axis !== s.axis) begin
                $error("out_axis: expected %0d, actual %0d", s.axis, axis);
                errors++;
            end
            if (line_a !== s.line_a) begin
                $error("line_a: expected %0d, actual %0d", s.line_a, line_a);
                errors++;
            end
            if (line_b !== s.line_b) begin
                $error("line_b: expected %0d, actual %0d", s.line_b, line_b);
                errors++;
            end
            if (hold_us !== s.hold_us) begin
                $error("hold_us: expected %0d, actual %0d", s.hold_us, hold_us);
                errors++;
            end
            if (last !== s.last) begin
                $error("last: expected %0d, actual %0d", s.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DELTA_W-1:0]     s_tdata;   // [7:0] delta
    logic                   s_tuser;   // [0] axis
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [0] line_a, [1] line_b, [17:2] hold_us
    logic                   m_tuser;   // [0] out_axis
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [HOLD_W-1:0]      cfg_data;

    qpg_step_scoreboard sb = new();
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;

    quadrature_pulse_generator #(
        .MAX_PULSES (MAX_STEPS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: check each step transaction, stall at random
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_step(m_tuser, m_tdata[0], m_tdata[1], m_tdata[17:2], m_tlast);
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_delta(input logic axis, input logic [DELTA_W-1:0] delta);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= delta;
        s_tuser  <= axis;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_delta(axis, delta);
    endtask

    // lets all pending steps drain, then waits out the settle time
    task automatic wait_idle();
        while (sb.pending_steps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_hold_config(input logic [HOLD_W-1:0] min_us,
                                    input logic [HOLD_W-1:0] max_us,
                                    input logic [THR_W-1:0] thr);
        logic [CFG_IDX_W-1:0] idx  [4];
        logic [HOLD_W-1:0]    vals [4];
        idx[0] = REG_UNUSED;    vals[0] = 16'($urandom_range(0, 65535));
        idx[1] = REG_MIN_HOLD;  vals[1] = min_us;
        idx[2] = REG_MAX_HOLD;  vals[2] = max_us;
        idx[3] = REG_SPEED_THR; vals[3] = 16'(thr);
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [DELTA_W-1:0] pick_delta();
        logic [DELTA_W-1:0] corner [8];
        int r;
        int mag;
        corner = '{8'h7F, 8'h80, 8'h40, 8'hC0, 8'h41, 8'hBF, 8'h01, 8'hFF};
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            mag = $urandom_range(1, 12);
            return $urandom_range(0, 1) ? 8'(mag) : 8'(256 - mag);
        end
        else if (r < 55)
            return '0;
        else if (r < 85)
            return 8'($urandom_range(0, 255));
        return corner[$urandom_range(0, 7)];
    endfunction

    initial
    begin
        logic [DELTA_W-1:0] dir_delta [22];
        logic               dir_axis  [22];
        logic [DELTA_W-1:0] d;
        logic [HOLD_W-1:0]  min_us;
        logic [HOLD_W-1:0]  max_us;
        logic [THR_W-1:0]   thr;
        int                 taken;

        cycle_count   = 0;
        send_idle_pct = 7;
        recv_idle_pct = 69;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single steps round the phase wheel, zero delta, threshold
        // edges, saturation at -128/+127/65, bit patterns, default config
        dir_delta = '{8'h01, 8'h01, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'h7F, 8'h80,
                      8'h00, 8'h00, 8'h05, 8'h06, 8'hFA, 8'h0F, 8'h10, 8'h40,
                      8'h41, 8'hC0, 8'hBF, 8'h55, 8'hAA, 8'h02};
        dir_axis  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                      1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
                      1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        for (int i = 0; i < 22; i++)
            send_delta(dir_axis[i], dir_delta[i]);
        s_tvalid <= 1'b0;

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 3)
                0:       begin send_idle_pct = 7;  recv_idle_pct = 69; end
                1:       begin send_idle_pct = 69; recv_idle_pct = 7;  end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            case (seg)
                0: begin min_us = 16'd0;     max_us = 16'd65535; thr = 7'd0;  end
                // min above max: hold floors at min, grows with the count, then saturates
                1: begin min_us = 16'd40000; max_us = 16'd30000; thr = 7'd0;  end
                3: begin min_us = 16'd500;   max_us = 16'd2000;  thr = 7'd64; end
                4: begin min_us = 16'd65535; max_us = 16'd65535; thr = 7'd64; end
                5: begin min_us = 16'd0;     max_us = 16'd0;     thr = 7'd1;  end
                7: begin min_us = 16'd1000;  max_us = 16'd3000;  thr = 7'd10; end
                default:
                begin
                    min_us = 16'($urandom_range(0, 65535));
                    max_us = 16'($urandom_range(0, 65535));
                    thr    = 7'($urandom_range(0, 64));
                end
            endcase
            wait_idle();
            load_hold_config(min_us, max_us, thr);

            taken = 0;
            while (taken < ITEMS_PER_SEG)
            begin
                d = pick_delta();
                send_delta(1'($urandom_range(0, 1)), d);
                if (d != '0)
                    taken++;
            end
            s_tvalid <= 1'b0;
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending_steps.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: quadrature_pulse_generator.f
rtl/qpg_pkg.sv
rtl/quadrature_pulse_generator.sv
rtl/qpg_checker.sv
tb/tb_quadrature_pulse_generator.sv
